/* src/ssrb_pkg.sv */
// ssrb_pkg: types, offsets and helpers for the shifter SPI register block.
// No dependencies; used by the top level, its checker and the testbench.
package ssrb_pkg;

  typedef struct packed {
    logic        operation;
    logic [11:0] byte_offset;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
    logic [7:0]  spi_reply_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        spi_send_valid;
    logic [7:0]  spi_send_byte;
    logic        chip_select;
    logic        irq;
  } out_word_t;

  localparam logic [31:0] ID_WORD0 = 32'h0201_0003;
  localparam logic [31:0] ID_WORD1 = 32'h0820_0808;
  localparam logic [2:0]  MODE_RX  = 3'd1;
  localparam logic [2:0]  MODE_TX  = 3'd2;

  localparam logic [11:0] OFF_ID0     = 12'h000;
  localparam logic [11:0] OFF_ID1     = 12'h004;
  localparam logic [11:0] OFF_CTRL    = 12'h008;
  localparam logic [11:0] OFF_PIN     = 12'h00C;
  localparam logic [11:0] OFF_SSTAT   = 12'h010;
  localparam logic [11:0] OFF_SERR    = 12'h014;
  localparam logic [11:0] OFF_TSTAT   = 12'h018;
  localparam logic [11:0] OFF_SIEN    = 12'h020;
  localparam logic [11:0] OFF_TIEN    = 12'h028;
  localparam logic [11:0] OFF_TRGSTAT = 12'h048;
  localparam logic [11:0] OFF_PINSTAT = 12'h050;
  localparam logic [11:0] OFF_POD     = 12'h060;
  localparam logic [11:0] OFF_POCLR   = 12'h06C;
  localparam logic [11:0] OFF_POSET   = 12'h070;
  localparam logic [11:0] OFF_POTOG   = 12'h074;
  // 32-byte aligned groups, compared on offset bits 11:5
  localparam logic [6:0]  GRP_SCTL    = 7'h04;
  localparam logic [6:0]  GRP_BUF     = 7'h10;
  localparam logic [6:0]  GRP_BUFBIS  = 7'h14;
  localparam int unsigned CS_PIN      = 4;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = b[7-k];
    return r;
  endfunction

endpackage

/* src/shifter_spi_register_block_top.sv */
// Top level of the shifter SPI register block: register window in one RAM,
// hot registers (control, status, enables, pins, shifter control and buffers) in flops.
// Depends on ssrb_pkg.
//
//  channel | ports                    | payload
//  input   | in_valid / in_stall      | in_word  (ssrb_pkg::in_word_t)
//  result  | out_valid / out_stall    | out_word (ssrb_pkg::out_word_t)
//
// Each access reads the addressed RAM word into a register, then modifies it and writes it back in ST_ACC.
// A new word is taken in ST_IDLE once the result register is free or being taken.
// After reset and after a soft reset a RAM clearing pass writes each of the WINDOW_WORDS words;
// in_stall stays high during it.
// A stalled result holds in the output register; the block waits for it.
module shifter_spi_register_block_top #(
  parameter int WINDOW_WORDS  = 1024,
  parameter int SHIFTER_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssrb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ssrb_pkg::out_word_t out_word
);

  localparam int AW = $clog2(WINDOW_WORDS);
  localparam int LIMIT = WINDOW_WORDS * 4;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [31:0] mem [WINDOW_WORDS];
  logic [31:0] mem_q_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  logic [1:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  ssrb_pkg::in_word_t  req_r, req_nxt;
  logic        out_valid_r, out_valid_nxt;
  ssrb_pkg::out_word_t out_r, out_nxt;

  logic [31:0] ctrl_r, ctrl_nxt, sstat_r, sstat_nxt, tstat_r, tstat_nxt;
  logic [31:0] sien_r, sien_nxt, tien_r, tien_nxt, pod_r, pod_nxt;
  logic [31:0] sctl_r [SHIFTER_COUNT];
  logic [31:0] sctl_nxt [SHIFTER_COUNT];
  logic [31:0] buf_r [SHIFTER_COUNT];
  logic [31:0] buf_nxt [SHIFTER_COUNT];
  logic [31:0] bis_r [SHIFTER_COUNT];
  logic [31:0] bis_nxt [SHIFTER_COUNT];

  logic        accept;
  logic        rd_en;

  assign in_stall  = !(state_r == ST_IDLE && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign rd_en     = accept && (32'(in_word.byte_offset) < 32'(LIMIT));
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    logic [11:0] idx;
    logic [4:0]  shamt;
    logic [31:0] lanes, mask, written, cur, v, rreg, rtx;
    logic        in_win, is_flop, hit_buf, hit_bis, sent, found;
    logic [7:0]  tx, rx, sbyte;
    logic [31:0] rdata;
    logic [SHIFTER_COUNT-1:0] sel;

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ctrl_nxt = ctrl_r; sstat_nxt = sstat_r; tstat_nxt = tstat_r;
    sien_nxt = sien_r; tien_nxt = tien_r; pod_nxt = pod_r;
    for (int i = 0; i < SHIFTER_COUNT; i++) begin
      sctl_nxt[i] = sctl_r[i];
      buf_nxt[i]  = buf_r[i];
      bis_nxt[i]  = bis_r[i];
    end
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = 32'd0;

    idx   = {req_r.byte_offset[11:2], 2'b00};
    shamt = {req_r.byte_offset[1:0], 3'b000};
    case (req_r.access_bytes)
      3'd0, 3'd1: lanes = 32'h0000_00FF;
      3'd2:       lanes = 32'h0000_FFFF;
      3'd3:       lanes = 32'h00FF_FFFF;
      default:    lanes = 32'hFFFF_FFFF;
    endcase
    mask    = lanes << shamt;
    written = (req_r.write_data << shamt) & mask;
    in_win  = 32'(req_r.byte_offset) < 32'(LIMIT);
    hit_buf = idx[11:5] == ssrb_pkg::GRP_BUF;
    hit_bis = idx[11:5] == ssrb_pkg::GRP_BUFBIS;

    // shifter lane addressed by bits 4:2, if it exists
    for (int i = 0; i < SHIFTER_COUNT; i++) sel[i] = (idx[4:2] == 3'(i));

    is_flop = 1'b1;
    cur     = mem_q_r;
    rtx     = 32'd0;
    case (idx)
      ssrb_pkg::OFF_CTRL:  cur = ctrl_r;
      ssrb_pkg::OFF_SSTAT: cur = sstat_r;
      ssrb_pkg::OFF_TSTAT: cur = tstat_r;
      ssrb_pkg::OFF_SIEN:  cur = sien_r;
      ssrb_pkg::OFF_TIEN:  cur = tien_r;
      ssrb_pkg::OFF_POD:   cur = pod_r;
      default:             is_flop = 1'b0;
    endcase
    for (int i = 0; i < SHIFTER_COUNT; i++) begin
      if (sel[i] && idx[11:5] == ssrb_pkg::GRP_SCTL) begin
        cur = sctl_r[i]; is_flop = 1'b1;
      end
      if (sel[i] && hit_buf) begin
        cur = buf_r[i]; is_flop = 1'b1;
      end
      if (sel[i] && hit_bis) begin
        cur = bis_r[i]; is_flop = 1'b1;
      end
      if (sctl_r[i][2:0] == ssrb_pkg::MODE_TX) rtx[i] = 1'b1;
    end
    v = (cur & ~mask) | written;

    rdata = 32'd0;
    sent  = 1'b0;
    sbyte = 8'd0;
    found = 1'b0;
    tx    = v[7:0];
    rx    = hit_bis ? req_r.spi_reply_byte : ssrb_pkg::rev8(req_r.spi_reply_byte);
    rreg  = cur;

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        if (clr_cnt_r == AW'(0))      mem_wd = ssrb_pkg::ID_WORD0;
        else if (clr_cnt_r == AW'(1)) mem_wd = ssrb_pkg::ID_WORD1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(WINDOW_WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_word;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_IDLE;
        mem_wa    = AW'(req_r.byte_offset[11:2]);
        mem_wd    = v;
        if (in_win && !req_r.operation) begin
          if (idx == ssrb_pkg::OFF_SSTAT) rreg = cur | rtx;
          rdata = (rreg >> shamt) & lanes;
          for (int i = 0; i < SHIFTER_COUNT; i++)
            if (sel[i] && (hit_buf || hit_bis) && sctl_r[i][2:0] == ssrb_pkg::MODE_RX)
              sstat_nxt[i] = 1'b0;
        end else if (in_win && idx != ssrb_pkg::OFF_ID0 && idx != ssrb_pkg::OFF_ID1
                     && idx != ssrb_pkg::OFF_PIN) begin
          case (idx)
            ssrb_pkg::OFF_SSTAT: sstat_nxt = cur & ~written;
            ssrb_pkg::OFF_TSTAT: tstat_nxt = cur & ~written;
            ssrb_pkg::OFF_SERR, ssrb_pkg::OFF_TRGSTAT, ssrb_pkg::OFF_PINSTAT: begin
              mem_we = 1'b1;
              mem_wd = cur & ~written;
            end
            ssrb_pkg::OFF_CTRL: begin
              if (v[1]) begin
                // soft reset: flops now, RAM via clearing pass
                ctrl_nxt = '0; sstat_nxt = '0; tstat_nxt = '0;
                sien_nxt = '0; tien_nxt = '0; pod_nxt = '0;
                for (int i = 0; i < SHIFTER_COUNT; i++) begin
                  sctl_nxt[i] = '0; buf_nxt[i] = '0; bis_nxt[i] = '0;
                end
                clr_cnt_nxt = '0;
                state_nxt   = ST_CLR;
              end else begin
                ctrl_nxt = v;
              end
            end
            ssrb_pkg::OFF_SIEN:  sien_nxt = v;
            ssrb_pkg::OFF_TIEN:  tien_nxt = v;
            ssrb_pkg::OFF_POD:   pod_nxt = v;
            ssrb_pkg::OFF_POSET: pod_nxt = pod_r | written;
            ssrb_pkg::OFF_POCLR: pod_nxt = pod_r & ~written;
            ssrb_pkg::OFF_POTOG: pod_nxt = pod_r ^ written;
            default: begin
              if (!is_flop) mem_we = 1'b1;
              for (int i = 0; i < SHIFTER_COUNT; i++) begin
                if (sel[i] && idx[11:5] == ssrb_pkg::GRP_SCTL) sctl_nxt[i] = v;
                if (sel[i] && hit_buf) buf_nxt[i] = v;
                if (sel[i] && hit_bis) bis_nxt[i] = v;
                if (sel[i] && (hit_buf || hit_bis) && ctrl_r[0]
                    && sctl_r[i][2:0] == ssrb_pkg::MODE_TX) begin
                  sent  = 1'b1;
                  sbyte = hit_bis ? tx : ssrb_pkg::rev8(tx);
                  sstat_nxt[i] = 1'b1;
                end
              end
              if (sent) begin
                // first receive shifter takes the reply
                for (int j = 0; j < SHIFTER_COUNT; j++) begin
                  if (!found && sctl_r[j][2:0] == ssrb_pkg::MODE_RX) begin
                    found = 1'b1;
                    buf_nxt[j]   = {24'd0, ssrb_pkg::rev8(rx)};
                    bis_nxt[j]   = {24'd0, rx};
                    sstat_nxt[j] = 1'b1;
                  end
                end
              end
            end
          endcase
        end
        out_valid_nxt          = 1'b1;
        out_nxt.read_data      = rdata;
        out_nxt.spi_send_valid = sent;
        out_nxt.spi_send_byte  = sbyte;
        out_nxt.chip_select    = pod_nxt[ssrb_pkg::CS_PIN];
        out_nxt.irq            = ((sstat_nxt & sien_nxt) != 32'd0)
                              || ((tstat_nxt & tien_nxt) != 32'd0);
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) mem_q_r <= mem[AW'(in_word.byte_offset[11:2])];
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ctrl_r <= '0; sstat_r <= '0; tstat_r <= '0;
      sien_r <= '0; tien_r <= '0; pod_r <= '0;
      for (int i = 0; i < SHIFTER_COUNT; i++) begin
        sctl_r[i] <= '0; buf_r[i] <= '0; bis_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ctrl_r <= ctrl_nxt; sstat_r <= sstat_nxt; tstat_r <= tstat_nxt;
      sien_r <= sien_nxt; tien_r <= tien_nxt; pod_r <= pod_nxt;
      for (int i = 0; i < SHIFTER_COUNT; i++) begin
        sctl_r[i] <= sctl_nxt[i]; buf_r[i] <= buf_nxt[i]; bis_r[i] <= bis_nxt[i];
      end
    end
  end

endmodule

/* src/ssrb_checker.sv */
// ssrb_checker: port-level assertions for the shifter SPI register block,
// bound to the top level. Depends on ssrb_pkg.
module ssrb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ssrb_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input ssrb_pkg::out_word_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken during an access");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result not shown two cycles after accept");

  a_no_send_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.spi_send_valid |-> out_word.spi_send_byte == 8'd0)
    else $error("send byte without a transfer");

endmodule

bind shifter_spi_register_block_top ssrb_checker u_ssrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* dv/shifter_spi_register_block_top_tb.sv */
// Testbench for shifter_spi_register_block_top: random and directed bus accesses,
// results checked against a predictor of the register window. Depends on ssrb_pkg.
`timescale 1ns / 1ps

module shifter_spi_register_block_top_tb;

  localparam int          NUM_SHIFTERS = 8;
  localparam int          NUM_WORDS    = 1024;
  localparam logic [11:0] SCTL_BASE    = {ssrb_pkg::GRP_SCTL, 5'b0};
  localparam logic [11:0] BUF_BASE     = {ssrb_pkg::GRP_BUF, 5'b0};
  localparam logic [11:0] BUFBIS_BASE  = {ssrb_pkg::GRP_BUFBIS, 5'b0};
  localparam bit          OP_READ      = 1'b0;
  localparam bit          OP_WRITE     = 1'b1;

  class access_scoreboard;
    logic [31:0]         win [NUM_WORDS];
    ssrb_pkg::out_word_t pending_results [$];
    int                  errors = 0;

    function void clear_window();
      foreach (win[k]) win[k] = '0;
      win[ssrb_pkg::OFF_ID0 >> 2] = ssrb_pkg::ID_WORD0;
      win[ssrb_pkg::OFF_ID1 >> 2] = ssrb_pkg::ID_WORD1;
    endfunction

    function logic [7:0] flip8(logic [7:0] b);
      return {<<{b}};
    endfunction

    function logic [2:0] mode_of(int i);
      return win[(SCTL_BASE >> 2) + i][2:0];
    endfunction

    // shifter index of a buffer alias, NUM_SHIFTERS if none
    function int buf_slot(logic [11:0] idx, output bit bis);
      bis = 1'b0;
      if (idx >= BUF_BASE && idx < BUF_BASE + 4 * NUM_SHIFTERS)
        return int'((idx - BUF_BASE) >> 2);
      if (idx >= BUFBIS_BASE && idx < BUFBIS_BASE + 4 * NUM_SHIFTERS) begin
        bis = 1'b1;
        return int'((idx - BUFBIS_BASE) >> 2);
      end
      return NUM_SHIFTERS;
    endfunction

    function ssrb_pkg::out_word_t predict_access(ssrb_pkg::in_word_t w);
      ssrb_pkg::out_word_t r;
      int unsigned sz, shift, t;
      logic [31:0] lanes, rv, mask, wv, cur, v;
      logic [11:0] idx;
      logic [7:0]  tx, rx;
      bit          bis;
      r = '0;
      sz = 32'(w.access_bytes);
      if (sz == 0) sz = 1;
      if (sz > 4) sz = 4;
      lanes = (sz == 4) ? 32'hFFFF_FFFF : (32'd1 << (sz * 8)) - 32'd1;
      idx = {w.byte_offset[11:2], 2'b00};
      shift = 32'(w.byte_offset[1:0]) * 8;
      if (w.operation == OP_READ) begin
        rv = win[idx >> 2];
        if (idx == ssrb_pkg::OFF_SSTAT)
          for (int i = 0; i < NUM_SHIFTERS; i++)
            if (mode_of(i) == ssrb_pkg::MODE_TX) rv[i] = 1'b1;
        t = buf_slot(idx, bis);
        if (t < NUM_SHIFTERS && mode_of(t) == ssrb_pkg::MODE_RX)
          win[ssrb_pkg::OFF_SSTAT >> 2][t] = 1'b0;
        r.read_data = (rv >> shift) & lanes;
      end else if (idx != ssrb_pkg::OFF_ID0 && idx != ssrb_pkg::OFF_ID1
                   && idx != ssrb_pkg::OFF_PIN) begin
        mask = lanes << shift;
        wv = (w.write_data << shift) & mask;
        cur = win[idx >> 2];
        v = (cur & ~mask) | wv;
        if (idx == ssrb_pkg::OFF_SSTAT || idx == ssrb_pkg::OFF_SERR ||
            idx == ssrb_pkg::OFF_TSTAT || idx == ssrb_pkg::OFF_TRGSTAT ||
            idx == ssrb_pkg::OFF_PINSTAT) begin
          win[idx >> 2] = cur & ~wv;
        end else if (idx == ssrb_pkg::OFF_CTRL) begin
          if (v[1]) clear_window();
          else win[idx >> 2] = v;
        end else if (idx == ssrb_pkg::OFF_POSET) begin
          win[ssrb_pkg::OFF_POD >> 2] |= wv;
        end else if (idx == ssrb_pkg::OFF_POCLR) begin
          win[ssrb_pkg::OFF_POD >> 2] &= ~wv;
        end else if (idx == ssrb_pkg::OFF_POTOG) begin
          win[ssrb_pkg::OFF_POD >> 2] ^= wv;
        end else begin
          win[idx >> 2] = v;
          t = buf_slot(idx, bis);
          if (t < NUM_SHIFTERS && win[ssrb_pkg::OFF_CTRL >> 2][0]
              && mode_of(t) == ssrb_pkg::MODE_TX) begin
            tx = v[7:0];
            rx = bis ? w.spi_reply_byte : flip8(w.spi_reply_byte);
            r.spi_send_valid = 1'b1;
            r.spi_send_byte = bis ? tx : flip8(tx);
            for (int i = 0; i < NUM_SHIFTERS; i++) begin
              if (mode_of(i) == ssrb_pkg::MODE_RX) begin
                win[(BUF_BASE >> 2) + i] = {24'd0, flip8(rx)};
                win[(BUFBIS_BASE >> 2) + i] = {24'd0, rx};
                win[ssrb_pkg::OFF_SSTAT >> 2][i] = 1'b1;
                break;
              end
            end
            win[ssrb_pkg::OFF_SSTAT >> 2][t] = 1'b1;
          end
        end
      end
      r.chip_select = win[ssrb_pkg::OFF_POD >> 2][ssrb_pkg::CS_PIN];
      r.irq = ((win[ssrb_pkg::OFF_SSTAT >> 2] & win[ssrb_pkg::OFF_SIEN >> 2]) != 0) ||
              ((win[ssrb_pkg::OFF_TSTAT >> 2] & win[ssrb_pkg::OFF_TIEN >> 2]) != 0);
      return r;
    endfunction

    function void note_access(ssrb_pkg::in_word_t w);
      pending_results.push_back(predict_access(w));
    endfunction

    function void check_result(ssrb_pkg::out_word_t got);
      ssrb_pkg::out_word_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.read_data !== exp_r.read_data) begin
        $error("read_data: expected %h, got %h", exp_r.read_data, got.read_data);
        errors++;
      end
      if (got.spi_send_valid !== exp_r.spi_send_valid) begin
        $error("spi_send_valid: expected %b, got %b", exp_r.spi_send_valid, got.spi_send_valid);
        errors++;
      end
      if (got.spi_send_byte !== exp_r.spi_send_byte) begin
        $error("spi_send_byte: expected %h, got %h", exp_r.spi_send_byte, got.spi_send_byte);
        errors++;
      end
      if (got.chip_select !== exp_r.chip_select) begin
        $error("chip_select: expected %b, got %b", exp_r.chip_select, got.chip_select);
        errors++;
      end
      if (got.irq !== exp_r.irq) begin
        $error("irq: expected %b, got %b", exp_r.irq, got.irq);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ssrb_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ssrb_pkg::out_word_t out_word;

  access_scoreboard sb = new();
  int idle_in_pct = 0;
  int idle_out_pct = 0;

  shifter_spi_register_block_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    out_stall <= ($urandom_range(99) < idle_out_pct);
  end

  task automatic send_word(input ssrb_pkg::in_word_t w);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_access(w);
  endtask

  task automatic access(input bit op, input logic [11:0] off, input logic [2:0] sz,
                        input logic [31:0] data, input logic [7:0] reply = 8'h00);
    ssrb_pkg::in_word_t w;
    w.operation = op;
    w.byte_offset = off;
    w.access_bytes = sz;
    w.write_data = data;
    w.spi_reply_byte = reply;
    send_word(w);
  endtask

  // mostly well-formed shifter traffic, some register churn, some noise
  task automatic random_access();
    ssrb_pkg::in_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.operation = OP_WRITE;
    w.access_bytes = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    w.write_data = $urandom();
    w.spi_reply_byte = 8'($urandom_range(255));
    w.byte_offset = 12'($urandom_range(3));
    if (pick < 35) begin
      w.byte_offset = 12'(($urandom_range(1) ? BUF_BASE : BUFBIS_BASE)
                      + 4 * $urandom_range(NUM_SHIFTERS - 1)
                      + (($urandom_range(5) == 0) ? $urandom_range(3) : 0));
    end else if (pick < 52) begin
      w.operation = OP_READ;
      case ($urandom_range(2))
        0: w.byte_offset = 12'(($urandom_range(1) ? BUF_BASE : BUFBIS_BASE)
                               + $urandom_range(31));
        1: w.byte_offset = ssrb_pkg::OFF_SSTAT + 12'($urandom_range(3));
        default: w.byte_offset = 12'($urandom_range(12'h0AF));
      endcase
    end else if (pick < 62) begin
      w.byte_offset = 12'(SCTL_BASE + 4 * $urandom_range(NUM_SHIFTERS - 1));
      if ($urandom_range(3) != 0) w.write_data[2:0] = 3'($urandom_range(2, 1));
    end else if (pick < 67) begin
      w.byte_offset = ssrb_pkg::OFF_CTRL
                      + 12'(($urandom_range(3) == 0) ? $urandom_range(3) : 0);
      w.write_data[0] = ($urandom_range(9) != 0);
    end else if (pick < 77) begin
      case ($urandom_range(3))
        0: w.byte_offset = ssrb_pkg::OFF_POSET;
        1: w.byte_offset = ssrb_pkg::OFF_POCLR;
        2: w.byte_offset = ssrb_pkg::OFF_POTOG;
        default: w.byte_offset = ssrb_pkg::OFF_POD;
      endcase
      w.byte_offset += 12'(($urandom_range(3) == 0) ? $urandom_range(3) : 0);
    end else if (pick < 87) begin
      case ($urandom_range(6))
        0: w.byte_offset = ssrb_pkg::OFF_SSTAT;
        1: w.byte_offset = ssrb_pkg::OFF_SERR;
        2: w.byte_offset = ssrb_pkg::OFF_TSTAT;
        3: w.byte_offset = ssrb_pkg::OFF_TRGSTAT;
        4: w.byte_offset = ssrb_pkg::OFF_PINSTAT;
        5: w.byte_offset = ssrb_pkg::OFF_TIEN;
        default: w.byte_offset = ssrb_pkg::OFF_SIEN;
      endcase
    end else begin
      w.operation = 1'($urandom_range(1));
      w.byte_offset = 12'($urandom_range(4095));
    end
    // soft reset costs a full clearing pass, keep it rare
    if (w.operation == OP_WRITE && w.byte_offset == ssrb_pkg::OFF_CTRL
        && $urandom_range(99) > 1)
      w.write_data[1] = 1'b0;
    send_word(w);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sb.clear_window();
    access(OP_READ, ssrb_pkg::OFF_ID0, 3'd4, '0);
    access(OP_READ, ssrb_pkg::OFF_ID1 + 12'd1, 3'd2, '0);
    access(OP_WRITE, ssrb_pkg::OFF_ID0, 3'd4, 32'hFFFF_FFFF);
    access(OP_WRITE, ssrb_pkg::OFF_PIN, 3'd4, 32'hFFFF_FFFF);
    access(OP_READ, 12'hFFF, 3'd4, '0);
    access(OP_READ, ssrb_pkg::OFF_ID0 + 12'd2, 3'd0, '0);
    access(OP_WRITE, ssrb_pkg::OFF_POSET, 3'd7, 32'h0000_0010);
    access(OP_WRITE, ssrb_pkg::OFF_POTOG, 3'd1, 32'h0000_00FF);
    access(OP_WRITE, ssrb_pkg::OFF_POCLR, 3'd4, 32'hFFFF_FFFF);
    access(OP_WRITE, ssrb_pkg::OFF_SIEN, 3'd4, 32'h0000_00FF);
    access(OP_WRITE, SCTL_BASE, 3'd1, {29'd0, ssrb_pkg::MODE_RX});
    access(OP_WRITE, SCTL_BASE + 12'd4, 3'd1, {29'd0, ssrb_pkg::MODE_TX});
    access(OP_WRITE, BUF_BASE + 12'd4, 3'd1, 32'h0000_00A5, 8'h3C);
    access(OP_WRITE, ssrb_pkg::OFF_CTRL, 3'd1, 32'h0000_0001);
    access(OP_WRITE, BUF_BASE + 12'd4, 3'd1, 32'h0000_00A5, 8'h3C);
    access(OP_WRITE, BUFBIS_BASE + 12'd4, 3'd4, 32'hFFFF_FF81, 8'hFF);
    access(OP_READ, ssrb_pkg::OFF_SSTAT, 3'd4, '0);
    access(OP_READ, BUF_BASE, 3'd4, '0);
    access(OP_READ, BUFBIS_BASE + 12'd3, 3'd4, '0);
    access(OP_WRITE, ssrb_pkg::OFF_SSTAT, 3'd4, 32'hFFFF_FFFF);
    access(OP_WRITE, ssrb_pkg::OFF_SERR + 12'd1, 3'd2, 32'hFFFF_FFFF);
    access(OP_WRITE, ssrb_pkg::OFF_TIEN, 3'd4, 32'hFFFF_FFFF);
    access(OP_WRITE, ssrb_pkg::OFF_CTRL, 3'd1, 32'h0000_0003);
    access(OP_READ, ssrb_pkg::OFF_CTRL, 3'd4, '0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_in_pct = (phase == 0) ? 11 : (phase == 1) ? 67 : 0;
      idle_out_pct = (phase == 0) ? 67 : (phase == 1) ? 11 : 0;
      repeat (560) random_access();
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("shifter_spi_register_block_top_tb: PASS");
    else $display("shifter_spi_register_block_top_tb: FAIL");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("shifter_spi_register_block_top_tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
src/ssrb_pkg.sv
src/shifter_spi_register_block_top.sv
src/ssrb_checker.sv
dv/shifter_spi_register_block_top_tb.sv
